// ===== hw/rtl/wrs_pkg.sv =====
package wrs_pkg;

  // Event codes on in_func
  localparam logic [2:0] FUNC_START  = 3'd0;
  localparam logic [2:0] FUNC_ACK    = 3'd1;
  localparam logic [2:0] FUNC_PAUSE  = 3'd2;
  localparam logic [2:0] FUNC_RESUME = 3'd3;
  localparam logic [2:0] FUNC_ABORT  = 3'd4;
  localparam logic [2:0] FUNC_TICK   = 3'd5;

  // Result kinds on out_kind
  localparam logic [2:0] KIND_STATUS   = 3'd0;
  localparam logic [2:0] KIND_STARTED  = 3'd1;
  localparam logic [2:0] KIND_COMPLETE = 3'd2;
  localparam logic [2:0] KIND_ERROR    = 3'd3;
  localparam logic [2:0] KIND_FRAME    = 3'd4;

  localparam logic ERR_BAD_REQUEST = 1'b0;
  localparam logic ERR_NO_DATA     = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_WINDOW_SIZE     = 2'd0;
  localparam logic [1:0] CFG_ACK_TIMEOUT     = 2'd1;
  localparam logic [1:0] CFG_FRAMES_PER_TICK = 2'd2;

  localparam logic [7:0]  WINDOW_RESET  = 8'd12;
  localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
  localparam logic [2:0]  FPT_RESET     = 3'd4;
  localparam logic [2:0]  FPT_MAX       = 3'd4;

  localparam logic [7:0] SRC_BLACKBOX = 8'd1;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LATCH,
    OP_EXEC,
    OP_START_OUT,
    OP_STATUS_OUT,
    OP_DONE_OUT,
    OP_FRAME,
    OP_FRAME_END
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_start;
    logic is_tick;
    logic active;
    logic paused;
    logic done;
    logic frame_ok;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hw/rtl/wrs_ctrl.sv =====
module wrs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wrs_pkg::dp_stat_t stat,
  output wrs_pkg::dp_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_START  = 6'b000100,
    S_STATUS = 6'b001000,
    S_DONE   = 6'b010000,
    S_FRAME  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = wrs_pkg::OP_NONE;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = wrs_pkg::OP_LATCH;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.op = wrs_pkg::OP_EXEC;
        if (stat.is_start) begin
          state_nxt = S_START;
        end else if (stat.is_tick && stat.active && !stat.paused) begin
          state_nxt = stat.done ? S_DONE : S_FRAME;
        end else begin
          state_nxt = S_STATUS;
        end
      end
      S_START: begin
        if (stat.out_free) begin
          cmd.op    = wrs_pkg::OP_START_OUT;
          state_nxt = S_IDLE;
        end
      end
      S_STATUS: begin
        if (stat.out_free) begin
          cmd.op    = wrs_pkg::OP_STATUS_OUT;
          state_nxt = S_IDLE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op    = wrs_pkg::OP_DONE_OUT;
          state_nxt = S_IDLE;
        end
      end
      S_FRAME: begin
        if (stat.out_free) begin
          if (stat.frame_ok) begin
            cmd.op = wrs_pkg::OP_FRAME;
          end else begin
            cmd.op    = wrs_pkg::OP_FRAME_END;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/wrs_dp.sv =====
module wrs_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  wrs_pkg::dp_cmd_t  cmd,
  output wrs_pkg::dp_stat_t stat,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_wdata,
  input  logic [2:0]        in_func,
  input  logic [31:0]       in_now_ms,
  input  logic [31:0]       in_request_start,
  input  logic [31:0]       in_request_end,
  input  logic [7:0]        in_request_source,
  input  logic [31:0]       in_ack_number,
  input  logic [31:0]       in_store_earliest,
  input  logic [31:0]       in_store_latest,
  input  logic              in_store_has_records,
  input  logic [31:0]       in_blackbox_latest,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_kind,
  output logic [31:0]       out_seq_first,
  output logic [31:0]       out_seq_second,
  output logic [7:0]        out_source_out,
  output logic              out_error_code,
  output logic              out_active_out,
  output logic              out_paused_out,
  output logic              out_last
);

  // configuration
  logic [7:0]  window_r;
  logic [15:0] timeout_r;
  logic [2:0]  fpt_r;

  // latched event word
  logic [2:0]  func_r;
  logic [31:0] now_r, req_s_r, req_e_r, ack_num_r, earliest_r, latest_r, bbl_r;
  logic [7:0]  req_src_r;
  logic        has_r;

  // stream state
  logic        active_r, active_nxt;
  logic        paused_r, paused_nxt;
  logic [7:0]  src_r, src_nxt;
  logic [31:0] end_r, end_nxt;
  logic [31:0] acked_r, acked_nxt;
  logic [31:0] highest_r, highest_nxt;
  logic [31:0] next_r, next_nxt;
  logic [31:0] last_ack_r, last_ack_nxt;

  // start clamp results
  logic [31:0] cs_r, cs_nxt, ce_r, ce_nxt;
  logic        nodata_r, nodata_nxt;

  // frame loop
  logic [2:0]  cnt_r, cnt_nxt;
  logic        pend_valid_r, pend_valid_nxt;
  logic [31:0] pend_seq_r, pend_seq_nxt;

  // output word
  logic        ov_r, ov_nxt;
  logic [2:0]  ok_r, ok_nxt;
  logic [31:0] of_r, of_nxt, os_r, os_nxt;
  logic [7:0]  osrc_r, osrc_nxt;
  logic        oerr_r, oerr_nxt, oact_r, oact_nxt, opau_r, opau_nxt, olast_r, olast_nxt;

  logic        out_free, done, frame_ok, bb, timed_out;
  logic [2:0]  limit;
  logic [31:0] in_flight, idle_ms;

  assign out_free  = !ov_r || out_ready;
  assign done      = acked_r >= end_r;
  assign limit     = (fpt_r > wrs_pkg::FPT_MAX) ? wrs_pkg::FPT_MAX : fpt_r;
  assign in_flight = highest_r - acked_r;
  assign idle_ms   = now_r - last_ack_r;
  assign timed_out = (highest_r > acked_r) && (idle_ms > {16'd0, timeout_r});
  assign frame_ok  = (cnt_r < limit) && (in_flight < {24'd0, window_r})
                     && !(highest_r >= end_r) && !(next_r > end_r);
  assign bb        = (req_src_r == wrs_pkg::SRC_BLACKBOX);

  assign stat.is_start = (func_r == wrs_pkg::FUNC_START);
  assign stat.is_tick  = (func_r == wrs_pkg::FUNC_TICK);
  assign stat.active   = active_r;
  assign stat.paused   = paused_r;
  assign stat.done     = done;
  assign stat.frame_ok = frame_ok;
  assign stat.out_free = out_free;

  always_comb begin
    active_nxt     = active_r;
    paused_nxt     = paused_r;
    src_nxt        = src_r;
    end_nxt        = end_r;
    acked_nxt      = acked_r;
    highest_nxt    = highest_r;
    next_nxt       = next_r;
    last_ack_nxt   = last_ack_r;
    cs_nxt         = cs_r;
    ce_nxt         = ce_r;
    nodata_nxt     = nodata_r;
    cnt_nxt        = cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_seq_nxt   = pend_seq_r;
    ov_nxt         = ov_r && !out_ready;
    ok_nxt         = ok_r;
    of_nxt         = of_r;
    os_nxt         = os_r;
    osrc_nxt       = osrc_r;
    oerr_nxt       = oerr_r;
    oact_nxt       = oact_r;
    opau_nxt       = opau_r;
    olast_nxt      = olast_r;
    case (cmd.op)
      wrs_pkg::OP_EXEC: begin
        cnt_nxt        = 3'd0;
        pend_valid_nxt = 1'b0;
        case (func_r)
          wrs_pkg::FUNC_START: begin
            nodata_nxt = bb ? (bbl_r == 32'd0) : (!has_r || latest_r == 32'd0);
            if (bb) begin
              cs_nxt = (req_s_r == 32'd0) ? 32'd1 : req_s_r;
              ce_nxt = (req_e_r == 32'd0 || req_e_r > bbl_r) ? bbl_r : req_e_r;
            end else begin
              cs_nxt = (req_s_r == 32'd0 || req_s_r < earliest_r) ? earliest_r : req_s_r;
              ce_nxt = (req_e_r == 32'd0 || req_e_r > latest_r) ? latest_r : req_e_r;
            end
          end
          wrs_pkg::FUNC_ACK: begin
            if (active_r && ack_num_r >= acked_r) begin
              acked_nxt    = (ack_num_r < end_r) ? ack_num_r : end_r;
              last_ack_nxt = now_r;
            end
          end
          wrs_pkg::FUNC_PAUSE: begin
            paused_nxt = 1'b1;
          end
          wrs_pkg::FUNC_RESUME: begin
            paused_nxt   = 1'b0;
            last_ack_nxt = now_r;
          end
          wrs_pkg::FUNC_ABORT: begin
            active_nxt   = 1'b0;
            paused_nxt   = 1'b0;
            src_nxt      = 8'd0;
            end_nxt      = 32'd0;
            acked_nxt    = 32'd0;
            highest_nxt  = 32'd0;
            next_nxt     = 32'd0;
            last_ack_nxt = 32'd0;
          end
          wrs_pkg::FUNC_TICK: begin
            // rewind to the first unacked frame after a silent spell
            if (active_r && !paused_r && !done && timed_out) begin
              next_nxt     = acked_r + 32'd1;
              highest_nxt  = acked_r;
              last_ack_nxt = now_r;
            end
          end
          default: begin
          end
        endcase
      end
      wrs_pkg::OP_START_OUT: begin
        ov_nxt    = 1'b1;
        olast_nxt = 1'b1;
        os_nxt    = 32'd0;
        if (nodata_r || cs_r > ce_r) begin
          ok_nxt   = wrs_pkg::KIND_ERROR;
          of_nxt   = 32'd0;
          osrc_nxt = src_r;
          oerr_nxt = nodata_r ? wrs_pkg::ERR_NO_DATA : wrs_pkg::ERR_BAD_REQUEST;
          oact_nxt = active_r;
          opau_nxt = paused_r;
        end else begin
          active_nxt   = 1'b1;
          paused_nxt   = 1'b0;
          src_nxt      = req_src_r;
          end_nxt      = ce_r;
          acked_nxt    = (cs_r != 32'd0) ? cs_r - 32'd1 : 32'd0;
          highest_nxt  = (cs_r != 32'd0) ? cs_r - 32'd1 : 32'd0;
          next_nxt     = cs_r;
          last_ack_nxt = now_r;
          ok_nxt       = wrs_pkg::KIND_STARTED;
          of_nxt       = cs_r;
          os_nxt       = ce_r;
          osrc_nxt     = req_src_r;
          oerr_nxt     = 1'b0;
          oact_nxt     = 1'b1;
          opau_nxt     = 1'b0;
        end
      end
      wrs_pkg::OP_STATUS_OUT: begin
        ov_nxt    = 1'b1;
        olast_nxt = 1'b1;
        os_nxt    = 32'd0;
        osrc_nxt  = src_r;
        oerr_nxt  = wrs_pkg::ERR_BAD_REQUEST;
        oact_nxt  = active_r;
        opau_nxt  = paused_r;
        if (func_r > wrs_pkg::FUNC_TICK) begin
          ok_nxt = wrs_pkg::KIND_ERROR;
          of_nxt = 32'd0;
        end else begin
          ok_nxt = wrs_pkg::KIND_STATUS;
          of_nxt = acked_r;
        end
      end
      wrs_pkg::OP_DONE_OUT: begin
        ov_nxt       = 1'b1;
        olast_nxt    = 1'b1;
        ok_nxt       = wrs_pkg::KIND_COMPLETE;
        of_nxt       = acked_r;
        os_nxt       = 32'd0;
        osrc_nxt     = src_r;
        oerr_nxt     = 1'b0;
        oact_nxt     = 1'b0;
        opau_nxt     = 1'b0;
        active_nxt   = 1'b0;
        paused_nxt   = 1'b0;
        src_nxt      = 8'd0;
        end_nxt      = 32'd0;
        acked_nxt    = 32'd0;
        highest_nxt  = 32'd0;
        next_nxt     = 32'd0;
        last_ack_nxt = 32'd0;
      end
      wrs_pkg::OP_FRAME: begin
        // hold the new frame back one step so the final one can carry last
        if (pend_valid_r) begin
          ov_nxt    = 1'b1;
          olast_nxt = 1'b0;
          ok_nxt    = wrs_pkg::KIND_FRAME;
          of_nxt    = pend_seq_r;
          os_nxt    = 32'd0;
          osrc_nxt  = src_r;
          oerr_nxt  = 1'b0;
          oact_nxt  = active_r;
          opau_nxt  = paused_r;
        end
        pend_valid_nxt = 1'b1;
        pend_seq_nxt   = next_r;
        highest_nxt    = (next_r > highest_r) ? next_r : highest_r;
        next_nxt       = next_r + 32'd1;
        cnt_nxt        = cnt_r + 3'd1;
      end
      wrs_pkg::OP_FRAME_END: begin
        ov_nxt         = 1'b1;
        olast_nxt      = 1'b1;
        os_nxt         = 32'd0;
        osrc_nxt       = src_r;
        oerr_nxt       = 1'b0;
        oact_nxt       = active_r;
        opau_nxt       = paused_r;
        pend_valid_nxt = 1'b0;
        if (pend_valid_r) begin
          ok_nxt = wrs_pkg::KIND_FRAME;
          of_nxt = pend_seq_r;
        end else begin
          ok_nxt = wrs_pkg::KIND_STATUS;
          of_nxt = acked_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= wrs_pkg::WINDOW_RESET;
      timeout_r    <= wrs_pkg::TIMEOUT_RESET;
      fpt_r        <= wrs_pkg::FPT_RESET;
      active_r     <= 1'b0;
      paused_r     <= 1'b0;
      src_r        <= 8'd0;
      end_r        <= 32'd0;
      acked_r      <= 32'd0;
      highest_r    <= 32'd0;
      next_r       <= 32'd0;
      last_ack_r   <= 32'd0;
      cnt_r        <= 3'd0;
      pend_valid_r <= 1'b0;
      ov_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wrs_pkg::CFG_WINDOW_SIZE:     window_r  <= cfg_wdata[7:0];
          wrs_pkg::CFG_ACK_TIMEOUT:     timeout_r <= cfg_wdata;
          wrs_pkg::CFG_FRAMES_PER_TICK: fpt_r     <= cfg_wdata[2:0];
          default: begin
          end
        endcase
      end
      active_r     <= active_nxt;
      paused_r     <= paused_nxt;
      src_r        <= src_nxt;
      end_r        <= end_nxt;
      acked_r      <= acked_nxt;
      highest_r    <= highest_nxt;
      next_r       <= next_nxt;
      last_ack_r   <= last_ack_nxt;
      cnt_r        <= cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      ov_r         <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == wrs_pkg::OP_LATCH) begin
      func_r     <= in_func;
      now_r      <= in_now_ms;
      req_s_r    <= in_request_start;
      req_e_r    <= in_request_end;
      req_src_r  <= in_request_source;
      ack_num_r  <= in_ack_number;
      earliest_r <= in_store_earliest;
      latest_r   <= in_store_latest;
      has_r      <= in_store_has_records;
      bbl_r      <= in_blackbox_latest;
    end
    cs_r       <= cs_nxt;
    ce_r       <= ce_nxt;
    nodata_r   <= nodata_nxt;
    pend_seq_r <= pend_seq_nxt;
    ok_r       <= ok_nxt;
    of_r       <= of_nxt;
    os_r       <= os_nxt;
    osrc_r     <= osrc_nxt;
    oerr_r     <= oerr_nxt;
    oact_r     <= oact_nxt;
    opau_r     <= opau_nxt;
    olast_r    <= olast_nxt;
  end

  assign out_valid      = ov_r;
  assign out_kind       = ok_r;
  assign out_seq_first  = of_r;
  assign out_seq_second = os_r;
  assign out_source_out = osrc_r;
  assign out_error_code = oerr_r;
  assign out_active_out = oact_r;
  assign out_paused_out = opau_r;
  assign out_last       = olast_r;

endmodule

// ===== hw/rtl/windowed_replay_sender.sv =====
// Flow: a word is taken at one edge and applied in the next cycle; its result is then loaded
// into the output register by a result step, which waits while the output register is full.
// A sending tick adds one frame step per frame and one step to close the burst; all frames
// share the single frame step.
// Throughput: the next word is taken the cycle after the final result is loaded; a full output
// register holds each result step. Reset: synchronous, active low; clears the stream, loads 12/3000/4.
module windowed_replay_sender (
  input  logic        clk,
  input  logic        rst_n,
  // event channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_now_ms,
  input  logic [31:0] in_request_start,
  input  logic [31:0] in_request_end,
  input  logic [7:0]  in_request_source,
  input  logic [31:0] in_ack_number,
  input  logic [31:0] in_store_earliest,
  input  logic [31:0] in_store_latest,
  input  logic        in_store_has_records,
  input  logic [31:0] in_blackbox_latest,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [31:0] out_seq_first,
  output logic [31:0] out_seq_second,
  output logic [7:0]  out_source_out,
  output logic        out_error_code,
  output logic        out_active_out,
  output logic        out_paused_out,
  output logic        out_last,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  // Command and status between the sequencer and the datapath. The sequencer
  // decides which step runs each cycle; the datapath holds the stream state,
  // the window arithmetic and the output register.
  wrs_pkg::dp_cmd_t  cmd;
  wrs_pkg::dp_stat_t stat;

  // Sequencer: take a word, apply it, then emit one result per cycle
  // while the output register is free.
  wrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: range clamp for start, ack tracking, timeout rewind and the
  // frame step. Frames are held back one step so the final one carries last.
  wrs_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_func              (in_func),
    .in_now_ms            (in_now_ms),
    .in_request_start     (in_request_start),
    .in_request_end       (in_request_end),
    .in_request_source    (in_request_source),
    .in_ack_number        (in_ack_number),
    .in_store_earliest    (in_store_earliest),
    .in_store_latest      (in_store_latest),
    .in_store_has_records (in_store_has_records),
    .in_blackbox_latest   (in_blackbox_latest),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_kind             (out_kind),
    .out_seq_first        (out_seq_first),
    .out_seq_second       (out_seq_second),
    .out_source_out       (out_source_out),
    .out_error_code       (out_error_code),
    .out_active_out       (out_active_out),
    .out_paused_out       (out_paused_out),
    .out_last             (out_last)
  );

  // An accepted word is always applied in the very next cycle.
  a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (cmd.op == wrs_pkg::OP_EXEC))
    else $error("accepted word not applied next cycle");

  // Never take a word while a result step or frame step is running.
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (cmd.op == wrs_pkg::OP_NONE || cmd.op == wrs_pkg::OP_LATCH))
    else $error("input ready during a working step");

  // A frame step only runs inside the window and with room at the output.
  a_frame_guarded: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == wrs_pkg::OP_FRAME) |-> (stat.frame_ok && stat.out_free))
    else $error("frame issued outside window or into a full output");

  // Closing steps leave a valid result flagged last.
  a_close_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == wrs_pkg::OP_FRAME_END || cmd.op == wrs_pkg::OP_START_OUT ||
     cmd.op == wrs_pkg::OP_STATUS_OUT || cmd.op == wrs_pkg::OP_DONE_OUT)
    |=> (out_valid && out_last))
    else $error("closing result not marked last");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  // Event codes the block must reject as bad requests
  localparam logic [2:0] FUNC_BAD_LO = 3'd6;
  localparam logic [2:0] FUNC_BAD_HI = 3'd7;

  // Cycles without any handshake before the run is abandoned
  localparam int STALL_LIMIT = 1000;
  // Quiet cycles after the last result word
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES = 7;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] now_ms;
    logic [31:0] req_start;
    logic [31:0] req_end;
    logic [7:0]  req_source;
    logic [31:0] ack_number;
    logic [31:0] earliest;
    logic [31:0] latest;
    logic        has_records;
    logic [31:0] bb_latest;
  } event_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] seq_first;
    logic [31:0] seq_second;
    logic [7:0]  source;
    logic        error_code;
    logic        active;
    logic        paused;
    logic        last;
  } result_word_t;

  typedef struct packed {
    event_word_t  ev;
    logic         typed;
    result_word_t want;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_func;
  logic [31:0] in_now_ms;
  logic [31:0] in_request_start;
  logic [31:0] in_request_end;
  logic [7:0]  in_request_source;
  logic [31:0] in_ack_number;
  logic [31:0] in_store_earliest;
  logic [31:0] in_store_latest;
  logic        in_store_has_records;
  logic [31:0] in_blackbox_latest;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [31:0] out_seq_first;
  logic [31:0] out_seq_second;
  logic [7:0]  out_source_out;
  logic        out_error_code;
  logic        out_active_out;
  logic        out_paused_out;
  logic        out_last;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  windowed_replay_sender DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_func              (in_func),
    .in_now_ms            (in_now_ms),
    .in_request_start     (in_request_start),
    .in_request_end       (in_request_end),
    .in_request_source    (in_request_source),
    .in_ack_number        (in_ack_number),
    .in_store_earliest    (in_store_earliest),
    .in_store_latest      (in_store_latest),
    .in_store_has_records (in_store_has_records),
    .in_blackbox_latest   (in_blackbox_latest),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_kind             (out_kind),
    .out_seq_first        (out_seq_first),
    .out_seq_second       (out_seq_second),
    .out_source_out       (out_source_out),
    .out_error_code       (out_error_code),
    .out_active_out       (out_active_out),
    .out_paused_out       (out_paused_out),
    .out_last             (out_last),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  // 12 ns period: low half then high half
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sender state as the testbench believes it to be, plus its register copies
  // ---------------------------------------------------------------------------
  logic [7:0]  win_size;
  logic [15:0] ack_timeout;
  logic [2:0]  per_tick;

  logic        st_active;
  logic        st_paused;
  logic [7:0]  st_source;
  logic [31:0] st_end;
  logic [31:0] st_acked;
  logic [31:0] st_high;
  logic [31:0] st_next;
  logic [31:0] st_last_ack;

  result_word_t due_words[$];   // result words still owed by the block, oldest first
  result_word_t burst[$];       // result words raised by the event in hand

  int mismatches = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  int stall_pct = 0;

  // Phase plan: register settings, length and how much idling each side does
  logic [15:0] ph_window  [PHASES] = '{16'd1, 16'd255, 16'd3, 16'd0, 16'hFF06, 16'd8, 16'd12};
  logic [15:0] ph_timeout [PHASES] = '{16'd1, 16'hFFFF, 16'd400, 16'd0, 16'd0, 16'd150,
                                       16'd3000};
  logic [15:0] ph_ticks   [PHASES] = '{16'd1, 16'd4, 16'd2, 16'd7, 16'd5, 16'd0, 16'd4};
  int          ph_items   [PHASES] = '{70, 70, 70, 40, 60, 30, 110};
  int          ph_idle    [PHASES] = '{25, 0, 40, 20, 30, 15, 0};

  function automatic void clear_stream_state();
    st_active   = 1'b0;
    st_paused   = 1'b0;
    st_source   = 8'd0;
    st_end      = 32'd0;
    st_acked    = 32'd0;
    st_high     = 32'd0;
    st_next     = 32'd0;
    st_last_ack = 32'd0;
  endfunction

  // Append one result word, stamped with the stream flags as they stand now
  function automatic void note_result(input logic [2:0] kind, input logic [31:0] a,
                                      input logic [31:0] b, input logic [7:0] src,
                                      input logic err);
    result_word_t r;
    if (burst.size() < 4) begin
      r = '{kind, a, b, src, err, st_active, st_paused, 1'b0};
      burst.push_back(r);
    end
  endfunction

  // Apply one event to the believed state and collect the words it raises in burst
  function automatic void advance_sender(input event_word_t w);
    logic [31:0] s;
    logic [31:0] e;
    logic [31:0] fin;
    logic [7:0]  fsrc;
    logic [2:0]  limit;
    logic        bb;
    result_word_t tail;
    burst.delete();
    case (w.func)
      wrs_pkg::FUNC_START: begin
        bb = (w.req_source == wrs_pkg::SRC_BLACKBOX);
        s  = w.req_start;
        e  = w.req_end;
        if ((!bb && (!w.has_records || w.latest == 32'd0)) || (bb && w.bb_latest == 32'd0)) begin
          // nothing to replay: keep any running stream as it is
          note_result(wrs_pkg::KIND_ERROR, 32'd0, 32'd0, st_source, wrs_pkg::ERR_NO_DATA);
        end else begin
          // zero means the store bound; clamp to what the store holds
          if (bb) begin
            if (s == 32'd0) s = 32'd1;
            if (e == 32'd0 || e > w.bb_latest) e = w.bb_latest;
          end else begin
            if (s == 32'd0 || s < w.earliest) s = w.earliest;
            if (e == 32'd0 || e > w.latest) e = w.latest;
          end
          if (s > e) begin
            note_result(wrs_pkg::KIND_ERROR, 32'd0, 32'd0, st_source,
                        wrs_pkg::ERR_BAD_REQUEST);
          end else begin
            clear_stream_state();
            st_active   = 1'b1;
            st_source   = w.req_source;
            st_end      = e;
            st_acked    = (s > 32'd0) ? s - 32'd1 : 32'd0;
            st_high     = st_acked;
            st_next     = s;
            st_last_ack = w.now_ms;
            note_result(wrs_pkg::KIND_STARTED, s, e, w.req_source, 1'b0);
          end
        end
      end
      wrs_pkg::FUNC_ACK: begin
        // stale acks drop; anything else moves the ack point, capped at the end
        if (st_active && w.ack_number >= st_acked) begin
          st_acked    = (w.ack_number < st_end) ? w.ack_number : st_end;
          st_last_ack = w.now_ms;
        end
      end
      wrs_pkg::FUNC_PAUSE: st_paused = 1'b1;
      wrs_pkg::FUNC_RESUME: begin
        st_paused   = 1'b0;
        st_last_ack = w.now_ms;
      end
      wrs_pkg::FUNC_ABORT: clear_stream_state();
      wrs_pkg::FUNC_TICK: begin
        if (st_active && !st_paused) begin
          if (st_acked >= st_end) begin
            fin  = st_acked;
            fsrc = st_source;
            clear_stream_state();
            note_result(wrs_pkg::KIND_COMPLETE, fin, 32'd0, fsrc, 1'b0);
          end else begin
            // go back to the first unacked frame once the ack is overdue
            if (st_high > st_acked && (w.now_ms - st_last_ack) > {16'd0, ack_timeout}) begin
              st_next     = st_acked + 32'd1;
              st_high     = st_acked;
              st_last_ack = w.now_ms;
            end
            limit = (per_tick > wrs_pkg::FPT_MAX) ? wrs_pkg::FPT_MAX : per_tick;
            for (int k = 0; k < limit; k++) begin
              if ((st_high - st_acked) >= {24'd0, win_size}) break;
              if (st_high >= st_end || st_next > st_end) break;
              note_result(wrs_pkg::KIND_FRAME, st_next, 32'd0, st_source, 1'b0);
              if (st_next > st_high) st_high = st_next;
              st_next = st_next + 32'd1;
            end
          end
        end
      end
      default: note_result(wrs_pkg::KIND_ERROR, 32'd0, 32'd0, st_source,
                           wrs_pkg::ERR_BAD_REQUEST);
    endcase
    if (burst.size() == 0) note_result(wrs_pkg::KIND_STATUS, st_acked, 32'd0, st_source, 1'b0);
    tail = burst.pop_back();
    tail.last = 1'b1;
    burst.push_back(tail);
  endfunction

  function automatic event_word_t ev(input logic [2:0] f, input logic [31:0] t,
                                     input logic [31:0] s, input logic [31:0] e,
                                     input logic [7:0] src, input logic [31:0] ack,
                                     input logic [31:0] ea, input logic [31:0] la,
                                     input logic has, input logic [31:0] bbl);
    ev = '{f, t, s, e, src, ack, ea, la, has, bbl};
  endfunction

  // Row whose single result word is written out by hand
  function automatic table_row_t checked(input event_word_t w, input logic [2:0] k,
                                         input logic [31:0] a, input logic [31:0] b,
                                         input logic [7:0] src, input logic err,
                                         input logic act, input logic pau);
    checked = '{w, 1'b1, '{k, a, b, src, err, act, pau, 1'b1}};
  endfunction

  // Row left to the predictor
  function automatic table_row_t predicted(input event_word_t w);
    predicted = '{w, 1'b0, '0};
  endfunction

  // ---------------------------------------------------------------------------
  // Event channel driver: change on the falling edge, hold until taken
  // ---------------------------------------------------------------------------
  task automatic send_word(input event_word_t w, input logic typed, input result_word_t want,
                           input int gap_pct);
    int gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 6) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_func              = w.func;
    in_now_ms            = w.now_ms;
    in_request_start     = w.req_start;
    in_request_end       = w.req_end;
    in_request_source    = w.req_source;
    in_ack_number        = w.ack_number;
    in_store_earliest    = w.earliest;
    in_store_latest      = w.latest;
    in_store_has_records = w.has_records;
    in_blackbox_latest   = w.bb_latest;
    in_valid             = 1'b1;
    do @(posedge clk); while (!in_ready);
    // the word is taken at this edge: work out what it owes
    advance_sender(w);
    if (typed) begin
      burst.delete();
      burst.push_back(want);
    end
    foreach (burst[k]) due_words.push_back(burst[k]);
  endtask

  // Drop valid and hold until every owed word is out and the block has gone quiet
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    wait (due_words.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      wrs_pkg::CFG_WINDOW_SIZE:     win_size    = data[7:0];
      wrs_pkg::CFG_ACK_TIMEOUT:     ack_timeout = data;
      wrs_pkg::CFG_FRAMES_PER_TICK: per_tick    = data[2:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result channel: stall in random bursts at the current rate
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 5);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare every word taken against the oldest one owed
  always @(posedge clk) begin
    result_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_words.size() == 0) begin
        $error("result word with none owed: kind %0d seq_first %0h", out_kind, out_seq_first);
        mismatches++;
      end else begin
        want = due_words.pop_front();
        if (out_kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_kind);
          mismatches++;
        end
        if (out_seq_first !== want.seq_first) begin
          $error("seq_first: expected %0h, actual %0h", want.seq_first, out_seq_first);
          mismatches++;
        end
        if (out_seq_second !== want.seq_second) begin
          $error("seq_second: expected %0h, actual %0h", want.seq_second, out_seq_second);
          mismatches++;
        end
        if (out_source_out !== want.source) begin
          $error("source_out: expected %0d, actual %0d", want.source, out_source_out);
          mismatches++;
        end
        if (out_error_code !== want.error_code) begin
          $error("error_code: expected %0d, actual %0d", want.error_code, out_error_code);
          mismatches++;
        end
        if (out_active_out !== want.active) begin
          $error("active_out: expected %0d, actual %0d", want.active, out_active_out);
          mismatches++;
        end
        if (out_paused_out !== want.paused) begin
          $error("paused_out: expected %0d, actual %0d", want.paused, out_paused_out);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: give up after a long spell with no handshake on any port
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    table_row_t  opening_rows[$];
    event_word_t w;
    logic [31:0] clock_ms;
    logic [31:0] base;
    logic [31:0] span;
    logic [31:0] t0;
    int          roll;
    logic        make_start;
    logic        start_ok;

    rst_n                = 1'b0;
    in_valid             = 1'b0;
    in_func              = wrs_pkg::FUNC_START;
    in_now_ms            = 32'd0;
    in_request_start     = 32'd0;
    in_request_end       = 32'd0;
    in_request_source    = 8'd0;
    in_ack_number        = 32'd0;
    in_store_earliest    = 32'd0;
    in_store_latest      = 32'd0;
    in_store_has_records = 1'b0;
    in_blackbox_latest   = 32'd0;
    cfg_we               = 1'b0;
    cfg_index            = wrs_pkg::CFG_WINDOW_SIZE;
    cfg_wdata            = 16'd0;

    win_size    = wrs_pkg::WINDOW_RESET;
    ack_timeout = wrs_pkg::TIMEOUT_RESET;
    per_tick    = wrs_pkg::FPT_RESET;
    clear_stream_state();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Opening table, run at the reset settings, in order: quiet events, the
    // four ways a start is refused, a stream at the very top of the sequence
    // space that is ticked, acked, paused, timed out across a wrap of the
    // millisecond clock and completed; then a blackbox start, bad code, abort.
    t0 = 32'hFFFF_F000;
    opening_rows.push_back(checked(ev(wrs_pkg::FUNC_PAUSE, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                   wrs_pkg::KIND_STATUS, 0, 0, 0, 0, 0, 1));
    opening_rows.push_back(checked(ev(wrs_pkg::FUNC_RESUME, '1, '1, '1, 8'hFF, '1, '1, '1, 1,
                                      '1),
                                   wrs_pkg::KIND_STATUS, 0, 0, 0, 0, 0, 0));
    opening_rows.push_back(checked(ev(FUNC_BAD_LO, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                   wrs_pkg::KIND_ERROR, 0, 0, 0, wrs_pkg::ERR_BAD_REQUEST,
                                   0, 0));
    opening_rows.push_back(checked(ev(FUNC_BAD_HI, '1, 0, 0, 0, 0, 0, 0, 1, 0),
                                   wrs_pkg::KIND_ERROR, 0, 0, 0, wrs_pkg::ERR_BAD_REQUEST,
                                   0, 0));
    opening_rows.push_back(checked(ev(wrs_pkg::FUNC_TICK, 32'd5000, 0, 0, 0, 0, 0, 0, 0, 0),
                                   wrs_pkg::KIND_STATUS, 0, 0, 0, 0, 0, 0));
    opening_rows.push_back(checked(ev(wrs_pkg::FUNC_ACK, 32'd5001, 0, 0, 0, '1, 0, 0, 0, 0),
                                   wrs_pkg::KIND_STATUS, 0, 0, 0, 0, 0, 0));
    opening_rows.push_back(checked(ev(wrs_pkg::FUNC_ABORT, 32'd5002, 0, 0, 0, 0, 0, 0, 0, 0),
                                   wrs_pkg::KIND_STATUS, 0, 0, 0, 0, 0, 0));
    // main log with no records, main log with latest zero, empty blackbox
    opening_rows.push_back(checked(ev(wrs_pkg::FUNC_START, 0, 0, 0, 8'd0, 0, 32'd1, 32'd100,
                                      0, 0),
                                   wrs_pkg::KIND_ERROR, 0, 0, 0, wrs_pkg::ERR_NO_DATA, 0, 0));
    opening_rows.push_back(checked(ev(wrs_pkg::FUNC_START, 0, 0, 0, 8'hFF, 0, 32'd1, 32'd0,
                                      1, 32'd9),
                                   wrs_pkg::KIND_ERROR, 0, 0, 0, wrs_pkg::ERR_NO_DATA, 0, 0));
    opening_rows.push_back(checked(ev(wrs_pkg::FUNC_START, 0, 0, 0, wrs_pkg::SRC_BLACKBOX, 0,
                                      32'd1, 32'd50, 1, 32'd0),
                                   wrs_pkg::KIND_ERROR, 0, 0, 0, wrs_pkg::ERR_NO_DATA, 0, 0));
    // start beyond the clamped end
    opening_rows.push_back(checked(ev(wrs_pkg::FUNC_START, 0, 32'd30, 0, 8'd2, 0, 32'd10,
                                      32'd20, 1, 0),
                                   wrs_pkg::KIND_ERROR, 0, 0, 0, wrs_pkg::ERR_BAD_REQUEST,
                                   0, 0));
    opening_rows.push_back(checked(ev(wrs_pkg::FUNC_START, t0, 0, 0, 8'hFF, 0,
                                      32'hFFFF_FFF0, '1, 1, 0),
                                   wrs_pkg::KIND_STARTED, 32'hFFFF_FFF0, '1, 8'hFF, 0, 1, 0));
    opening_rows.push_back(predicted(ev(wrs_pkg::FUNC_TICK, t0 + 1, 0, 0, 0, 0, 0, 0, 0, 0)));
    opening_rows.push_back(predicted(ev(wrs_pkg::FUNC_TICK, t0 + 2, 0, 0, 0, 0, 0, 0, 0, 0)));
    opening_rows.push_back(predicted(ev(wrs_pkg::FUNC_TICK, t0 + 3, 0, 0, 0, 0, 0, 0, 0, 0)));
    opening_rows.push_back(predicted(ev(wrs_pkg::FUNC_ACK, t0 + 32'h10, 0, 0, 0,
                                        32'hFFFF_FFF5, 0, 0, 0, 0)));
    opening_rows.push_back(predicted(ev(wrs_pkg::FUNC_PAUSE, t0 + 32'h20, 0, 0, 0, 0, 0, 0, 0,
                                        0)));
    opening_rows.push_back(predicted(ev(wrs_pkg::FUNC_TICK, t0 + 32'h21, 0, 0, 0, 0, 0, 0, 0,
                                        0)));
    opening_rows.push_back(predicted(ev(wrs_pkg::FUNC_RESUME, t0 + 32'h30, 0, 0, 0, 0, 0, 0,
                                        0, 0)));
    opening_rows.push_back(predicted(ev(wrs_pkg::FUNC_TICK, 32'h200, 0, 0, 0, 0, 0, 0, 0, 0)));
    opening_rows.push_back(predicted(ev(wrs_pkg::FUNC_ACK, 32'h210, 0, 0, 0, '1, 0, 0, 0, 0)));
    opening_rows.push_back(checked(ev(wrs_pkg::FUNC_TICK, 32'h220, 0, 0, 0, 0, 0, 0, 0, 0),
                                   wrs_pkg::KIND_COMPLETE, '1, 0, 8'hFF, 0, 0, 0));
    opening_rows.push_back(predicted(ev(wrs_pkg::FUNC_START, 32'h300, 0, 0,
                                        wrs_pkg::SRC_BLACKBOX, 0, 0, 0, 0, 32'd5)));
    opening_rows.push_back(checked(ev(FUNC_BAD_HI, 32'h301, 0, 0, 0, 0, 0, 0, 0, 0),
                                   wrs_pkg::KIND_ERROR, 0, 0, wrs_pkg::SRC_BLACKBOX,
                                   wrs_pkg::ERR_BAD_REQUEST, 1, 0));
    opening_rows.push_back(predicted(ev(wrs_pkg::FUNC_ABORT, 32'h302, 0, 0, 0, 0, 0, 0, 0,
                                        0)));

    stall_pct = 30;
    foreach (opening_rows[r]) send_word(opening_rows[r].ev, opening_rows[r].typed,
                                        opening_rows[r].want, 30);

    // Random phases: each starts idle with fresh register settings
    clock_ms = $urandom;
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      write_reg(wrs_pkg::CFG_WINDOW_SIZE, ph_window[p]);
      write_reg(wrs_pkg::CFG_ACK_TIMEOUT, ph_timeout[p]);
      write_reg(wrs_pkg::CFG_FRAMES_PER_TICK, ph_ticks[p]);
      stall_pct = ph_idle[p];

      for (int i = 0; i < ph_items[p]; i++) begin
        // hold the sender once mid-phase until the block has caught up
        if (p == 1 && i == ph_items[p] / 2) drain_results();

        // fill every field with noise, then shape the ones that matter
        w = '{func: wrs_pkg::FUNC_TICK, now_ms: 0, req_start: $urandom, req_end: $urandom,
              req_source: 8'($urandom), ack_number: $urandom, earliest: $urandom,
              latest: $urandom, has_records: 1'($urandom), bb_latest: $urandom};

        // advance the millisecond clock: mostly small steps, now and then past
        // the ack timeout, rarely an arbitrary jump
        roll = $urandom_range(0, 99);
        if (roll < 70) clock_ms = clock_ms + $urandom_range(0, 40);
        else if (roll < 96) clock_ms = clock_ms + $urandom_range(0, 2 * ack_timeout + 20);
        else clock_ms = $urandom;
        w.now_ms = clock_ms;

        make_start = 1'b0;
        start_ok   = 1'b1;
        roll = $urandom_range(0, 99);
        if (!st_active) begin
          if (roll < 65) make_start = 1'b1;
          else if (roll < 80) begin
            make_start = 1'b1;
            start_ok   = 1'b0;
          end else if (roll < 95) begin
            w.func = 3'($urandom_range(wrs_pkg::FUNC_ACK, wrs_pkg::FUNC_TICK));
          end else w.func = 3'($urandom_range(FUNC_BAD_LO, FUNC_BAD_HI));
        end else if (st_paused && roll < 40) begin
          w.func = wrs_pkg::FUNC_RESUME;
        end else begin
          if (roll < 50) w.func = wrs_pkg::FUNC_TICK;
          else if (roll < 74) begin
            // ack somewhere between the ack point and just past what is out, now and then a stale one
            w.func = wrs_pkg::FUNC_ACK;
            if (st_high >= st_acked && st_high - st_acked < 32'd1000) begin
              if ($urandom_range(0, 9) == 0) w.ack_number = st_acked - 32'd1;
              else w.ack_number = st_acked + $urandom_range(0, st_high - st_acked + 1);
            end
          end else if (roll < 80) w.func = wrs_pkg::FUNC_PAUSE;
          else if (roll < 84) w.func = wrs_pkg::FUNC_RESUME;
          else if (roll < 88) w.func = wrs_pkg::FUNC_ABORT;
          else if (roll < 93) begin
            make_start = 1'b1;
            start_ok   = ($urandom_range(0, 1) == 0);
          end else if (roll < 97) w.func = wrs_pkg::FUNC_ACK;
          else w.func = 3'($urandom_range(FUNC_BAD_LO, FUNC_BAD_HI));
        end

        if (make_start) begin
          w.func = wrs_pkg::FUNC_START;
          base = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 60)
                                               : $urandom_range(1, 5000);
          span = $urandom_range(0, 40);
          if (start_ok) begin
            if ($urandom_range(0, 3) == 0) begin
              // blackbox replay, counted from one
              w.req_source = wrs_pkg::SRC_BLACKBOX;
              w.bb_latest  = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                                          : $urandom_range(1, 60);
              if ($urandom_range(0, 2) == 0) w.req_start = 32'd0;
              else w.req_start = w.bb_latest - $urandom_range(0, 20);
              if (w.req_start > w.bb_latest || w.req_start == 32'd0 && w.bb_latest > 60)
                w.req_start = w.bb_latest;
              if ($urandom_range(0, 2) == 0) w.req_end = 32'd0;
              else w.req_end = $urandom_range(w.req_start + 1, w.bb_latest)
                               + $urandom_range(0, 10);
            end else begin
              // main log replay inside, below or beyond the held range
              w.req_source = 8'($urandom_range(0, 255));
              if (w.req_source == wrs_pkg::SRC_BLACKBOX) w.req_source = 8'd0;
              w.has_records = 1'b1;
              w.earliest    = base;
              w.latest      = base + span;
              case ($urandom_range(0, 3))
                0: w.req_start = 32'd0;
                1: w.req_start = $urandom_range(0, w.earliest);
                default: w.req_start = $urandom_range(w.earliest, w.latest);
              endcase
              case ($urandom_range(0, 3))
                0: w.req_end = 32'd0;
                1: w.req_end = w.latest + $urandom_range(1, 100);
                default: w.req_end = $urandom_range((w.req_start > w.earliest) ? w.req_start
                                                                             : w.earliest,
                                                    w.latest);
              endcase
            end
          end else begin
            case ($urandom_range(0, 3))
              0: begin
                w.req_source  = 8'd0;
                w.has_records = 1'b0;
              end
              1: begin
                w.req_source  = 8'hFF;
                w.has_records = 1'b1;
                w.latest      = 32'd0;
              end
              2: begin
                w.req_source = wrs_pkg::SRC_BLACKBOX;
                w.bb_latest  = 32'd0;
              end
              default: begin
                // start past the end of a well-filled main log
                w.req_source  = 8'($urandom_range(2, 255));
                w.has_records = 1'b1;
                w.earliest    = $urandom_range(1, 5000);
                w.latest      = w.earliest + span;
                w.req_start   = w.latest + $urandom_range(1, 50);
                w.req_end     = 32'd0;
              end
            endcase
          end
        end

        send_word(w, 1'b0, '0, ph_idle[p]);
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
